/* rtl/sfcs_pkg.sv */
// shared types, codes and reset values for the serial flash command sequencer
// no dependencies; imported by every module of the block

package sfcs_pkg;

    // default width of the data byte counter
    localparam int SFCS_COUNT_BITS = 16;

    // request codes carried by req_type
    typedef enum logic [2:0] {
        REQ_READ_ID = 3'd0,
        REQ_ERASE   = 3'd1,
        REQ_READ    = 3'd2,
        REQ_PROGRAM = 3'd3,
        REQ_BYTE    = 3'd4
    } t_req;

    // operation held while a sequence runs
    typedef enum logic [1:0] {
        OP_READ_ID = 2'd0,
        OP_ERASE   = 2'd1,
        OP_READ    = 2'd2,
        OP_PROGRAM = 2'd3
    } t_op;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_WREN      = 4'd1,
        PH_POLL_OP   = 4'd2,
        PH_POLL_DATA = 4'd3,
        PH_OPCODE    = 4'd4,
        PH_ADDR      = 4'd5,
        PH_DATA      = 4'd6,
        PH_ID_OP     = 4'd7,
        PH_ID_DATA   = 4'd8
    } t_phase;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ID_OPCODE      = 3'd0,
        CFG_WREN_OPCODE    = 3'd1,
        CFG_ERASE_OPCODE   = 3'd2,
        CFG_READ_OPCODE    = 3'd3,
        CFG_STATUS_OPCODE  = 3'd4,
        CFG_PROGRAM_OPCODE = 3'd5,
        CFG_FILLER_BYTE    = 3'd6
    } t_cfg_idx;

    // configuration reset values
    localparam logic [7:0] RST_ID_OPCODE      = 8'h9F;
    localparam logic [7:0] RST_WREN_OPCODE    = 8'h06;
    localparam logic [7:0] RST_ERASE_OPCODE   = 8'h20;
    localparam logic [7:0] RST_READ_OPCODE    = 8'h03;
    localparam logic [7:0] RST_STATUS_OPCODE  = 8'h05;
    localparam logic [7:0] RST_PROGRAM_OPCODE = 8'h02;
    localparam logic [7:0] RST_FILLER_BYTE    = 8'hFF;

    // status register busy bit
    localparam int STATUS_BUSY_BIT = 0;

    typedef struct packed {
        logic [7:0] id_opcode;
        logic [7:0] write_enable_opcode;
        logic [7:0] erase_opcode;
        logic [7:0] read_opcode;
        logic [7:0] status_opcode;
        logic [7:0] program_opcode;
        logic [7:0] filler_byte;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [23:0] flash_address;
        logic [15:0] byte_count;
        logic [7:0]  write_byte;
        logic [7:0]  returned_byte;
    } t_item;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        select_release;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic [23:0] device_id;
        logic        done_res;
        logic        busy_reject;
    } t_result;

endpackage

/* rtl/sfcs_cfg_regs.sv */
// opcode and filler byte register file of the flash command sequencer
// depends on sfcs_pkg for the register indexes and reset values

module sfcs_cfg_regs
    import sfcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  logic [2:0] i_index,
    input  logic [7:0] i_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    // register writes, out-of-range indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.id_opcode           <= RST_ID_OPCODE;
            r_cfg.write_enable_opcode <= RST_WREN_OPCODE;
            r_cfg.erase_opcode        <= RST_ERASE_OPCODE;
            r_cfg.read_opcode         <= RST_READ_OPCODE;
            r_cfg.status_opcode       <= RST_STATUS_OPCODE;
            r_cfg.program_opcode      <= RST_PROGRAM_OPCODE;
            r_cfg.filler_byte         <= RST_FILLER_BYTE;
        end else if (i_wr_en) begin
            case (i_index)
                CFG_ID_OPCODE:      r_cfg.id_opcode           <= i_data;
                CFG_WREN_OPCODE:    r_cfg.write_enable_opcode <= i_data;
                CFG_ERASE_OPCODE:   r_cfg.erase_opcode        <= i_data;
                CFG_READ_OPCODE:    r_cfg.read_opcode         <= i_data;
                CFG_STATUS_OPCODE:  r_cfg.status_opcode       <= i_data;
                CFG_PROGRAM_OPCODE: r_cfg.program_opcode      <= i_data;
                CFG_FILLER_BYTE:    r_cfg.filler_byte         <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/sfcs_in_stage.sv */
// input register of the flash command sequencer, one word deep
// depends on sfcs_pkg for the input word type

module sfcs_in_stage
    import sfcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // held word blocks the input until the sequencer takes it
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_take) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/sfcs_step.sv */
// sequencer state machine: one input word in, at most one result word out
// depends on sfcs_pkg for phases, codes and word types

module sfcs_step
    import sfcs_pkg::*;
#(
    parameter int COUNT_BITS = SFCS_COUNT_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    input  logic    i_out_free,
    input  t_cfg    i_cfg,
    output logic    o_take,
    output logic    o_load,
    output t_result o_result
);

    t_phase                r_phase,   n_phase;
    t_op                   r_op,      n_op;
    logic [1:0]            r_hdr_idx, n_hdr_idx;
    logic [COUNT_BITS-1:0] r_left,    n_left;
    logic [23:0]           r_addr,    n_addr;
    logic [23:0]           r_id_acc,  n_id_acc;

    t_result               res;
    logic                  has_res;
    logic [1:0]            hdr_inc;
    logic [23:0]           id_next;
    logic [COUNT_BITS-1:0] left_dec;
    logic                  left_zero;
    logic [7:0]            op_opcode;
    logic [7:0]            data_out;

    // a word is processed when the result register can take its result
    assign o_take = i_valid && i_out_free;
    assign o_load = o_take && has_res;
    assign o_result = res;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_op      <= OP_READ_ID;
            r_hdr_idx <= '0;
            r_left    <= '0;
            r_addr    <= '0;
            r_id_acc  <= '0;
        end else if (o_take) begin
            r_phase   <= n_phase;
            r_op      <= n_op;
            r_hdr_idx <= n_hdr_idx;
            r_left    <= n_left;
            r_addr    <= n_addr;
            r_id_acc  <= n_id_acc;
        end
    end

    // helper values for the step
    assign hdr_inc   = r_hdr_idx + 2'd1;
    assign id_next   = {r_id_acc[15:0], i_item.returned_byte};
    assign left_dec  = r_left - COUNT_BITS'(1);
    assign left_zero = (r_left == '0);
    assign data_out  = (r_op == OP_READ) ? i_cfg.filler_byte : i_item.write_byte;

    always_comb begin
        case (r_op)
            OP_ERASE: op_opcode = i_cfg.erase_opcode;
            OP_READ:  op_opcode = i_cfg.read_opcode;
            default:  op_opcode = i_cfg.program_opcode;
        endcase
    end

    // next state and result
    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_hdr_idx = r_hdr_idx;
        n_left    = r_left;
        n_addr    = r_addr;
        n_id_acc  = r_id_acc;
        res       = '0;
        has_res   = 1'b0;

        case (i_item.req_type)
            REQ_BYTE: begin
                if (r_phase != PH_IDLE) begin
                    has_res = 1'b1;
                    case (r_phase)
                        PH_ID_OP: begin
                            n_phase        = PH_ID_DATA;
                            n_hdr_idx      = '0;
                            res.send_valid = 1'b1;
                            res.send_byte  = i_cfg.filler_byte;
                        end
                        PH_ID_DATA: begin
                            n_id_acc  = id_next;
                            n_hdr_idx = hdr_inc;
                            if (hdr_inc == 2'd3) begin
                                n_phase       = PH_IDLE;
                                res.done_res  = 1'b1;
                                res.device_id = id_next;
                            end else begin
                                res.send_valid     = 1'b1;
                                res.send_byte      = i_cfg.filler_byte;
                                res.select_release = (hdr_inc == 2'd2);
                            end
                        end
                        PH_WREN: begin
                            n_phase        = PH_POLL_OP;
                            res.send_valid = 1'b1;
                            res.send_byte  = i_cfg.status_opcode;
                        end
                        PH_POLL_OP: begin
                            n_phase            = PH_POLL_DATA;
                            res.send_valid     = 1'b1;
                            res.send_byte      = i_cfg.filler_byte;
                            res.select_release = 1'b1;
                        end
                        PH_POLL_DATA: begin
                            res.send_valid = 1'b1;
                            // keep polling while the flash reports busy
                            if (i_item.returned_byte[STATUS_BUSY_BIT]) begin
                                n_phase       = PH_POLL_OP;
                                res.send_byte = i_cfg.status_opcode;
                            end else begin
                                n_phase       = PH_OPCODE;
                                res.send_byte = op_opcode;
                            end
                        end
                        PH_OPCODE: begin
                            n_phase        = PH_ADDR;
                            n_hdr_idx      = '0;
                            res.send_valid = 1'b1;
                            res.send_byte  = r_addr[23:16];
                        end
                        PH_ADDR: begin
                            n_hdr_idx = hdr_inc;
                            if (hdr_inc != 2'd3) begin
                                res.send_valid     = 1'b1;
                                res.send_byte      = (hdr_inc == 2'd1) ? r_addr[15:8]
                                                                       : r_addr[7:0];
                                res.select_release = (hdr_inc == 2'd2) &&
                                                     (r_op == OP_ERASE || left_zero);
                            end else if (r_op == OP_ERASE || left_zero) begin
                                n_phase      = PH_IDLE;
                                res.done_res = 1'b1;
                            end else begin
                                n_phase            = PH_DATA;
                                res.send_valid     = 1'b1;
                                res.send_byte      = data_out;
                                res.select_release = (r_left == COUNT_BITS'(1));
                            end
                        end
                        PH_DATA: begin
                            if (r_op == OP_READ) begin
                                res.read_valid = 1'b1;
                                res.read_byte  = i_item.returned_byte;
                            end
                            n_left = left_dec;
                            if (left_dec == '0) begin
                                n_phase      = PH_IDLE;
                                res.done_res = 1'b1;
                            end else begin
                                res.send_valid     = 1'b1;
                                res.send_byte      = data_out;
                                res.select_release = (left_dec == COUNT_BITS'(1));
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            has_res = 1'b0;
                        end
                    endcase
                end
            end
            REQ_READ_ID, REQ_ERASE, REQ_READ, REQ_PROGRAM: begin
                has_res = 1'b1;
                if (r_phase != PH_IDLE) begin
                    res.busy_reject = 1'b1;
                end else begin
                    n_op           = t_op'(i_item.req_type[1:0]);
                    n_addr         = i_item.flash_address;
                    n_left         = COUNT_BITS'(i_item.byte_count);
                    n_hdr_idx      = '0;
                    res.send_valid = 1'b1;
                    case (i_item.req_type)
                        REQ_READ_ID: begin
                            n_id_acc      = '0;
                            n_phase       = PH_ID_OP;
                            res.send_byte = i_cfg.id_opcode;
                        end
                        REQ_READ: begin
                            n_phase       = PH_POLL_OP;
                            res.send_byte = i_cfg.status_opcode;
                        end
                        default: begin
                            n_phase            = PH_WREN;
                            res.send_byte      = i_cfg.write_enable_opcode;
                            res.select_release = 1'b1;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/sfcs_out_stage.sv */
// result register of the flash command sequencer with stall handling
// depends on sfcs_pkg for the result word type

module sfcs_out_stage
    import sfcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held word leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/spi_flash_command_sequencer_unit.sv */
// top level of the serial nor flash command sequencer
// depends on sfcs_pkg, sfcs_cfg_regs, sfcs_in_stage, sfcs_step, sfcs_out_stage

// Usage
// The input channel carries one word per host request (read id, sector erase,
// read, program) or per byte returned by the spi shifter. The output channel
// carries the next byte to shift out with its chip select release flag, read
// data, the assembled device id, the done flag and the busy reject flag.
// Requests and returned bytes never produce more than one output word; a
// returned byte while idle or an unknown request code produces none.
// An accepted input word is held in the input register, and its result word is
// then loaded into the result register once that register is free.
// Throughput: one word per cycle unless stalled; each word makes a single
// pass through the sequencer state register, words following back to back.
// Stall: a stalled result word holds in the result register while the input
// register still takes one more word; after that o_in_stall rises.
// Reset: synchronous, active low; the sequencer returns to idle, both
// registers empty, and the opcode registers take their default values.
// Configuration writes are always ready and take effect on the next cycle;
// they are meant for idle periods only.

module spi_flash_command_sequencer_unit
    import sfcs_pkg::*;
#(
    parameter int COUNT_BITS = SFCS_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_req_type,
    input  logic [23:0] i_flash_address,
    input  logic [15:0] i_byte_count,
    input  logic [7:0]  i_write_byte,
    input  logic [7:0]  i_returned_byte,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_send_valid,
    output logic [7:0]  o_send_byte,
    output logic        o_select_release,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic [23:0] o_device_id,
    output logic        o_done_res,
    output logic        o_busy_reject,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_cfg    cfg;
    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    step_take;
    logic    step_load;
    t_result step_result;
    logic    out_free;
    t_result out_result;

    // configuration
    assign o_cfg_ready = 1'b1;

    sfcs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // input word
    assign in_item.req_type      = i_req_type;
    assign in_item.flash_address = i_flash_address;
    assign in_item.byte_count    = i_byte_count;
    assign in_item.write_byte    = i_write_byte;
    assign in_item.returned_byte = i_returned_byte;

    sfcs_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .i_take  (step_take),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    // sequencer
    sfcs_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (held_valid),
        .i_item     (held_item),
        .i_out_free (out_free),
        .i_cfg      (cfg),
        .o_take     (step_take),
        .o_load     (step_load),
        .o_result   (step_result)
    );

    // result word
    sfcs_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step_load),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_send_valid     = out_result.send_valid;
    assign o_send_byte      = out_result.send_byte;
    assign o_select_release = out_result.select_release;
    assign o_read_valid     = out_result.read_valid;
    assign o_read_byte      = out_result.read_byte;
    assign o_device_id      = out_result.device_id;
    assign o_done_res       = out_result.done_res;
    assign o_busy_reject    = out_result.busy_reject;

`ifndef SYNTHESIS
    // a busy reject carries no other flag
    a_reject_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_busy_reject) |->
            (!o_send_valid && !o_read_valid && !o_done_res))
        else $error("busy reject combined with other result flags");

    // the device id is only shown on a done word
    a_id_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_device_id == 24'd0))
        else $error("device id shown without done");

    // no byte value or chip select release without send valid
    a_send_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_send_valid) |-> (o_send_byte == 8'd0 && !o_select_release))
        else $error("send byte or release without send valid");

    // done and a sent byte never share a word
    a_done_no_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_send_valid)
        else $error("done word also sends a byte");
`endif

endmodule
